### rtl/hse_pkg.sv
// Shared types, constants and helpers for the half-sphere exposure counter.
package hse_pkg;

    localparam int DEF_MAX_RESIDUES = 1024;
    localparam int DEF_COORD_BITS   = 24;

    localparam int CUT_W    = 16;
    localparam int D_W      = CUT_W + 1;
    localparam int CNT_W    = 10;
    localparam int QIDX_W   = 10;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int MAC_STEP_W = 4;

    localparam logic [CUT_W-1:0] CUTOFF_RESET = 16'd13000;
    localparam logic [CNT_W-1:0] COUNT_MAX    = 10'd1023;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_CUTOFF   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_USE_BETA = 1'd1;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RANGE   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_DROPPED = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_QRD,
        S_CLR,
        S_ROW_RD,
        S_ROW_LD,
        S_PAIR_RD,
        S_PAIR_DIFF,
        S_MAC,
        S_PAIR_WR,
        S_ROW_WR
    } t_state;

    typedef struct packed {
        logic done;
        logic in_range;
        logic up_i;
        logic up_j;
    } t_mac_res;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        sat_inc = (c < COUNT_MAX) ? c + 1'b1 : c;
    endfunction

endpackage

### rtl/hse_mac.sv
// Shared multiply-accumulate unit: distance test and both half-sphere dot products.
module hse_mac #(
    parameter int V_W = hse_pkg::DEF_COORD_BITS + 1
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [hse_pkg::CUT_W-1:0]       i_cutoff,
    input  logic signed [hse_pkg::D_W-1:0]  i_d  [3],
    input  logic signed [V_W-1:0]           i_vi [3],
    input  logic signed [V_W-1:0]           i_vj [3],
    output hse_pkg::t_mac_res               o_res
);
    import hse_pkg::*;

    localparam int PW    = D_W + V_W;
    localparam int ACC_W = PW + 2;
    localparam logic [MAC_STEP_W-1:0] LAST_STEP = 4'd10;

    logic                  r_busy;
    logic                  r_done;
    logic [MAC_STEP_W-1:0] r_step;
    logic signed [PW-1:0]    r_prod;
    logic signed [ACC_W-1:0] r_sumsq;
    logic signed [ACC_W-1:0] r_dti;
    logic signed [ACC_W-1:0] r_dtj;
    logic signed [ACC_W-1:0] r_c2;

    logic signed [D_W-1:0] op_a;
    logic signed [V_W-1:0] op_b;
    logic signed [PW-1:0]  mul;
    logic signed [D_W-1:0] cut_s;

    assign cut_s = signed'({1'b0, i_cutoff});

    always_comb begin
        op_a = '0;
        op_b = '0;
        case (r_step)
            4'd0: begin op_a = i_d[0]; op_b = V_W'(i_d[0]); end
            4'd1: begin op_a = i_d[1]; op_b = V_W'(i_d[1]); end
            4'd2: begin op_a = i_d[2]; op_b = V_W'(i_d[2]); end
            4'd3: begin op_a = i_d[0]; op_b = i_vi[0]; end
            4'd4: begin op_a = i_d[1]; op_b = i_vi[1]; end
            4'd5: begin op_a = i_d[2]; op_b = i_vi[2]; end
            4'd6: begin op_a = i_d[0]; op_b = i_vj[0]; end
            4'd7: begin op_a = i_d[1]; op_b = i_vj[1]; end
            4'd8: begin op_a = i_d[2]; op_b = i_vj[2]; end
            4'd9: begin op_a = cut_s;  op_b = V_W'(cut_s); end
            default: begin op_a = '0; op_b = '0; end
        endcase
    end

    assign mul = op_a * op_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Accumulate the product of the previous step.
    always_ff @(posedge i_clk) begin
        r_prod <= mul;
        if (i_start) begin
            r_sumsq <= '0;
            r_dti   <= '0;
            r_dtj   <= '0;
        end else if (r_busy) begin
            case (r_step) inside
                [4'd1:4'd3]: r_sumsq <= r_sumsq + ACC_W'(r_prod);
                [4'd4:4'd6]: r_dti   <= r_dti + ACC_W'(r_prod);
                [4'd7:4'd9]: r_dtj   <= r_dtj + ACC_W'(r_prod);
                4'd10:       r_c2    <= ACC_W'(r_prod);
                default: ;
            endcase
        end
    end

    assign o_res.done     = r_done;
    assign o_res.in_range = (r_sumsq <= r_c2);
    assign o_res.up_i     = (r_dti > 0);
    assign o_res.up_j     = (r_dtj < 0);

endmodule

### rtl/half_sphere_exposure_counter.sv
// Top level: residue stores, count stores and the pair-pass sequencer.
//
// Input channel (i_in_valid / o_in_stall) takes load and query items. A load
// stores one residue; the load marked last starts the pair pass over all held
// residues. A query goes through S_QRD, which waits while an earlier result is
// stalled, and presents one result on the output channel (o_out_valid /
// i_out_stall); a finished result waits in the output register and the block
// takes new loads meanwhile. The pass clears the counts of the loaded residues,
// then reads each row's residue i and, for each later j, reads and differences
// the pair; a pair rejected on any one axis skips the shared multiplier, any
// other goes through it (ten multiplies: three squares, six dot terms, the
// squared cutoff). No item is taken during the pass. Loads past capacity are
// dropped and reported in the status of later queries.
// Reset clears the control state and the registers to their defaults; queries
// before the first load report every index as beyond the loaded residues.
// Configuration writes are taken at any cycle through i_cfg_we.
module half_sphere_exposure_counter #(
    parameter int MAX_RESIDUES = hse_pkg::DEF_MAX_RESIDUES,
    parameter int COORD_BITS   = hse_pkg::DEF_COORD_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_mode,
    input  logic signed [COORD_BITS-1:0]      i_ca_x,
    input  logic signed [COORD_BITS-1:0]      i_ca_y,
    input  logic signed [COORD_BITS-1:0]      i_ca_z,
    input  logic signed [COORD_BITS-1:0]      i_cb_x,
    input  logic signed [COORD_BITS-1:0]      i_cb_y,
    input  logic signed [COORD_BITS-1:0]      i_cb_z,
    input  logic                              i_last_residue,
    input  logic [hse_pkg::QIDX_W-1:0]        i_query_index,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [hse_pkg::QIDX_W-1:0]        o_residue_index,
    output logic [hse_pkg::CNT_W-1:0]         o_contacts,
    output logic [hse_pkg::CNT_W-1:0]         o_up_count,
    output logic [hse_pkg::CNT_W-1:0]         o_down_count,
    output logic [hse_pkg::STATUS_W-1:0]      o_status,
    input  logic                              i_cfg_we,
    input  logic [hse_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [hse_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import hse_pkg::*;

    localparam int IDX_W = (MAX_RESIDUES > 1) ? $clog2(MAX_RESIDUES) : 1;
    localparam int N_W   = IDX_W + 1;
    localparam int V_W   = COORD_BITS + 1;
    localparam int CMP_W = (QIDX_W > N_W) ? QIDX_W : N_W;
    localparam int QX_W  = IDX_W + QIDX_W;
    localparam int CW_W  = 3 * CNT_W;
    localparam logic [N_W-1:0] MAX_N = N_W'(MAX_RESIDUES);

    t_state r_state, n_state;

    logic [CUT_W-1:0]  r_cutoff;
    logic              r_use_beta;
    logic [N_W-1:0]    r_loaded;
    logic              r_overflow;
    logic              r_new_mol;
    logic              r_pass_done;
    logic [N_W-1:0]    r_i;
    logic [N_W-1:0]    r_j;
    logic [QIDX_W-1:0] r_q;
    logic              r_qbad;
    logic              r_hit;
    logic              r_up_i;
    logic              r_up_j;

    logic signed [COORD_BITS-1:0] r_pi [3];
    logic signed [V_W-1:0]        r_vi [3];
    logic signed [V_W-1:0]        r_vj [3];
    logic signed [D_W-1:0]        r_d  [3];
    logic [CNT_W-1:0] r_ci, r_ui, r_di;

    // Coordinate and count memories.
    logic signed [COORD_BITS-1:0] mem_ax [MAX_RESIDUES];
    logic signed [COORD_BITS-1:0] mem_ay [MAX_RESIDUES];
    logic signed [COORD_BITS-1:0] mem_az [MAX_RESIDUES];
    logic signed [COORD_BITS-1:0] mem_bx [MAX_RESIDUES];
    logic signed [COORD_BITS-1:0] mem_by [MAX_RESIDUES];
    logic signed [COORD_BITS-1:0] mem_bz [MAX_RESIDUES];
    logic [CW_W-1:0]              mem_cnt [MAX_RESIDUES];

    logic signed [COORD_BITS-1:0] r_m_a [3];
    logic signed [COORD_BITS-1:0] r_m_b [3];
    logic [CW_W-1:0]              r_m_cnt;

    logic             acc_in;
    logic             acc_load;
    logic             acc_query;
    logic [N_W-1:0]   load_k;
    logic             load_fits;
    logic             coord_we;
    logic [IDX_W-1:0] coord_ra;
    logic             cnt_we;
    logic [IDX_W-1:0] cnt_wa;
    logic [CW_W-1:0]  cnt_wd;
    logic [IDX_W-1:0] cnt_ra;
    logic [QX_W-1:0]  q_ext;
    logic             q_beyond;
    logic             out_load;
    logic             mac_start;
    t_mac_res         mac_res;

    logic signed [COORD_BITS-1:0] pj   [3];
    logic signed [V_W-1:0]        dfull [3];
    logic [V_W-1:0]               dabs [3];
    logic signed [V_W-1:0]        vj   [3];
    logic                         reject;
    logic [CNT_W-1:0] cj, uj, dj;
    logic [N_W:0]     i_plus2;
    logic [N_W:0]     j_plus1;
    logic [N_W:0]     clr_plus1;

    assign acc_in    = i_in_valid && !o_in_stall;
    assign acc_load  = acc_in && (i_mode == MODE_LOAD);
    assign acc_query = acc_in && (i_mode == MODE_QUERY);
    assign load_k    = r_new_mol ? '0 : r_loaded;
    assign load_fits = (load_k < MAX_N);
    assign q_ext     = QX_W'(i_query_index);
    assign q_beyond  = (CMP_W'(i_query_index) >= CMP_W'(r_loaded));
    assign i_plus2   = (N_W+1)'(r_i) + 2'd2;
    assign j_plus1   = (N_W+1)'(r_j) + 1'b1;
    assign clr_plus1 = (N_W+1)'(r_i) + 1'b1;

    assign {cj, uj, dj} = r_m_cnt;

    // Pair differences from the residue j read data.
    always_comb begin
        reject = 1'b0;
        for (int k = 0; k < 3; k++) begin
            pj[k]    = r_use_beta ? r_m_b[k] : r_m_a[k];
            dfull[k] = V_W'(pj[k]) - V_W'(r_pi[k]);
            dabs[k]  = dfull[k][V_W-1] ? V_W'(-dfull[k]) : V_W'(dfull[k]);
            vj[k]    = V_W'(r_m_b[k]) - V_W'(r_m_a[k]);
            if (dabs[k] > V_W'(r_cutoff)) begin
                reject = 1'b1;
            end
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (acc_query) begin
                    n_state = S_QRD;
                end else if (acc_load && i_last_residue) begin
                    n_state = S_CLR;
                end
            end
            S_QRD: begin
                if (!o_out_valid || !i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            S_CLR: begin
                if (clr_plus1 >= (N_W+1)'(r_loaded)) begin
                    n_state = (r_loaded < N_W'(2)) ? S_IDLE : S_ROW_RD;
                end
            end
            S_ROW_RD:    n_state = S_ROW_LD;
            S_ROW_LD:    n_state = S_PAIR_RD;
            S_PAIR_RD:   n_state = S_PAIR_DIFF;
            S_PAIR_DIFF: n_state = reject ? S_PAIR_WR : S_MAC;
            S_MAC: begin
                if (mac_res.done) begin
                    n_state = S_PAIR_WR;
                end
            end
            S_PAIR_WR: begin
                n_state = (j_plus1 < (N_W+1)'(r_loaded)) ? S_PAIR_RD : S_ROW_WR;
            end
            S_ROW_WR: begin
                n_state = (i_plus2 < (N_W+1)'(r_loaded)) ? S_ROW_RD : S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control outputs.
    always_comb begin
        o_in_stall = (r_state != S_IDLE);
        coord_we   = acc_load && load_fits;
        coord_ra   = (r_state == S_ROW_RD) ? r_i[IDX_W-1:0] : r_j[IDX_W-1:0];
        cnt_we     = 1'b0;
        cnt_wa     = r_j[IDX_W-1:0];
        cnt_wd     = '0;
        cnt_ra     = r_j[IDX_W-1:0];
        out_load   = 1'b0;
        mac_start  = 1'b0;
        unique case (r_state)
            S_IDLE:   cnt_ra = q_ext[IDX_W-1:0];
            S_QRD: begin
                cnt_ra   = IDX_W'(r_q);
                out_load = !o_out_valid || !i_out_stall;
            end
            S_CLR: begin
                cnt_we = 1'b1;
                cnt_wa = r_i[IDX_W-1:0];
            end
            S_ROW_RD: cnt_ra = r_i[IDX_W-1:0];
            S_PAIR_DIFF: mac_start = !reject;
            S_PAIR_WR: begin
                cnt_we = r_hit;
                cnt_wd = {sat_inc(cj),
                          r_up_j ? sat_inc(uj) : uj,
                          r_up_j ? dj : sat_inc(dj)};
            end
            S_ROW_WR: begin
                cnt_we = 1'b1;
                cnt_wa = r_i[IDX_W-1:0];
                cnt_wd = {r_ci, r_ui, r_di};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (coord_we) begin
            mem_ax[load_k[IDX_W-1:0]] <= i_ca_x;
            mem_ay[load_k[IDX_W-1:0]] <= i_ca_y;
            mem_az[load_k[IDX_W-1:0]] <= i_ca_z;
            mem_bx[load_k[IDX_W-1:0]] <= i_cb_x;
            mem_by[load_k[IDX_W-1:0]] <= i_cb_y;
            mem_bz[load_k[IDX_W-1:0]] <= i_cb_z;
        end
        r_m_a[0] <= mem_ax[coord_ra];
        r_m_a[1] <= mem_ay[coord_ra];
        r_m_a[2] <= mem_az[coord_ra];
        r_m_b[0] <= mem_bx[coord_ra];
        r_m_b[1] <= mem_by[coord_ra];
        r_m_b[2] <= mem_bz[coord_ra];
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            mem_cnt[cnt_wa] <= cnt_wd;
        end
        r_m_cnt <= mem_cnt[cnt_ra];
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cutoff    <= CUTOFF_RESET;
            r_use_beta  <= 1'b0;
            r_loaded    <= '0;
            r_overflow  <= 1'b0;
            r_new_mol   <= 1'b1;
            r_pass_done <= 1'b0;
            r_i         <= '0;
            r_j         <= '0;
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_CUTOFF:   r_cutoff   <= i_cfg_data[CUT_W-1:0];
                    REG_USE_BETA: r_use_beta <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (acc_load) begin
                r_new_mol   <= 1'b0;
                r_pass_done <= 1'b0;
                r_overflow  <= (r_new_mol ? 1'b0 : r_overflow) || !load_fits;
                r_loaded    <= load_fits ? load_k + 1'b1 : load_k;
                r_i         <= '0;
            end
            if (out_load) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLR: begin
                    if (clr_plus1 < (N_W+1)'(r_loaded)) begin
                        r_i <= r_i + 1'b1;
                    end else begin
                        r_i <= '0;
                        if (r_loaded < N_W'(2)) begin
                            r_pass_done <= 1'b1;
                            r_new_mol   <= 1'b1;
                        end
                    end
                end
                S_ROW_LD:  r_j <= r_i + 1'b1;
                S_PAIR_WR: r_j <= r_j + 1'b1;
                S_ROW_WR: begin
                    r_i <= r_i + 1'b1;
                    if (i_plus2 >= (N_W+1)'(r_loaded)) begin
                        r_pass_done <= 1'b1;
                        r_new_mol   <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (acc_query) begin
            r_q    <= i_query_index;
            r_qbad <= q_beyond;
        end
        case (r_state)
            S_ROW_LD: begin
                for (int k = 0; k < 3; k++) begin
                    r_pi[k] <= r_use_beta ? r_m_b[k] : r_m_a[k];
                    r_vi[k] <= V_W'(r_m_b[k]) - V_W'(r_m_a[k]);
                end
                {r_ci, r_ui, r_di} <= r_m_cnt;
            end
            S_PAIR_DIFF: begin
                for (int k = 0; k < 3; k++) begin
                    r_d[k]  <= dfull[k][D_W-1:0];
                    r_vj[k] <= vj[k];
                end
                r_hit <= 1'b0;
            end
            S_MAC: begin
                r_hit  <= mac_res.in_range;
                r_up_i <= mac_res.up_i;
                r_up_j <= mac_res.up_j;
            end
            S_PAIR_WR: begin
                if (r_hit) begin
                    r_ci <= sat_inc(r_ci);
                    if (r_up_i) begin
                        r_ui <= sat_inc(r_ui);
                    end else begin
                        r_di <= sat_inc(r_di);
                    end
                end
            end
            default: ;
        endcase
        if (out_load) begin
            o_residue_index <= r_q;
            if (r_qbad) begin
                o_contacts   <= '0;
                o_up_count   <= '0;
                o_down_count <= '0;
                o_status     <= STATUS_RANGE;
            end else begin
                o_contacts   <= r_pass_done ? cj : '0;
                o_up_count   <= r_pass_done ? uj : '0;
                o_down_count <= r_pass_done ? dj : '0;
                o_status     <= r_overflow ? STATUS_DROPPED : STATUS_OK;
            end
        end
    end

    hse_mac #(
        .V_W (V_W)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mac_start),
        .i_cutoff (r_cutoff),
        .i_d      (r_d),
        .i_vi     (r_vi),
        .i_vj     (r_vj),
        .o_res    (mac_res)
    );

endmodule
